[design/fas_pkg.sv]
// Package for the truncating single-precision add/subtract unit.
// Holds the beat types and field constants; no dependencies.
`default_nettype none
package fas_pkg;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW = 8;
  localparam int unsigned MantW = FracW + 1;

  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        opcode;
  } fas_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        exponent_out_of_range;
  } fas_out_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } fas_op_t;
endpackage
`default_nettype wire

[design/fas_datapath.sv]
// Combinational datapath: align, add or subtract, normalize, pack.
// Depends on fas_pkg.
`default_nettype none
module fas_datapath
  import fas_pkg::*;
(
  input  wire fas_in_t item,
  output fas_out_t     res
);
  logic              sa, sb, a_big, borrow, carry, zero_d;
  logic [ExpW-1:0]   ea, eb;
  logic [ExpW-1:0]   diff;
  logic [MantW-1:0]  ma, mb, msmall, mshift, la, rb, d, dn;
  logic [MantW:0]    sum;
  logic [4:0]        lz;
  logic [9:0]        e;
  logic              sign;
  logic [FracW-1:0]  frac;

  always_comb begin
    sa = item.operand_a[31];
    sb = item.operand_b[31] ^ (item.opcode == OP_SUB);
    ea = item.operand_a[30:23];
    eb = item.operand_b[30:23];
    ma = {1'b1, item.operand_a[FracW-1:0]};
    mb = {1'b1, item.operand_b[FracW-1:0]};
    a_big = ea >= eb;
    diff = a_big ? ea - eb : eb - ea;
    msmall = a_big ? mb : ma;
    borrow = 1'b0;
    if (diff != '0 && diff <= 8'd24) begin
      borrow = msmall[5'(diff - 8'd1)];
    end
    mshift = (diff >= 8'd24) ? '0 : msmall >> diff[4:0];
    la = a_big ? ma : mshift;
    rb = a_big ? mshift : mb;
    e = {2'b00, a_big ? ea : eb};
    sum = {1'b0, la} + {1'b0, rb};
    carry = sum[MantW];
    d = (la > rb) ? la - rb : rb - la;
    if (d != '0 && borrow) begin
      d = d - 1'b1;
    end
    zero_d = d == '0;
    lz = '0;
    for (int i = 0; i < MantW; i++) begin
      if (d[i]) begin
        lz = 5'(MantW - 1 - i);
      end
    end
    dn = d << lz;
    if (sa == sb) begin
      sign = sa;
      frac = carry ? sum[FracW:1] : sum[FracW-1:0];
      e = e + {9'd0, carry};
    end else begin
      sign = (la > rb) ? sa : sb;
      frac = dn[FracW-1:0];
      e = e - {5'd0, lz};
    end
    res = '0;
    if (sa != sb && zero_d) begin
      res = '0;
    end else if (e[9] || e == 10'd0 || e > 10'd254) begin
      res.exponent_out_of_range = 1'b1;
    end else begin
      res.result_bits = {sign, e[7:0], frac};
    end
  end
endmodule
`default_nettype wire

[design/float32_add_subtract_truncating_unit.sv]
// Top level of the truncating single-precision add/subtract unit.
// Depends on fas_pkg and fas_datapath.
//
// Usage: drive in_item and pulse start; busy is always low, so an item is
// taken at every edge where start is high. The item is registered, the
// datapath evaluates it in the next cycle, and the result is registered
// into out_item, shown with out_valid high for exactly one cycle. One item
// per cycle is sustained; the rate is set by the single pass through the
// align, add and normalize logic between the input and result registers.
// The receiver cannot stall: every result is shown for one cycle only.
// Reset clears the valid flags, so no result is emitted until an item has
// been taken.
`default_nettype none
module float32_add_subtract_truncating_unit
  import fas_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire fas_in_t  in_item,
  output logic          out_valid,
  output fas_out_t      out_item
);
  fas_in_t  item_r;
  logic     item_vld_r;
  fas_out_t res_nxt, out_r;
  logic     out_vld_r;

  assign busy = 1'b0;

  fas_datapath u_dp (.item(item_r), .res(res_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      item_vld_r <= start;
      out_vld_r <= item_vld_r;
    end
    item_r <= in_item;
    out_r <= res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item = out_r;

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.exponent_out_of_range |-> out_item.result_bits == '0)
    else $error("out of range result not zero");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("spurious result");
endmodule
`default_nettype wire
